@@ hw/rtl/dtc_pkg.sv @@
// shared types and constants for the dense-to-csr encoder
// no dependencies; imported by every module of the block
package dtc_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLUMNS = 1024;

  localparam int COUNT_W = 11;   // width of the row and column count registers
  localparam int POS_W   = 10;   // row and column positions
  localparam int TALLY_W = 21;   // nonzero tally and row pointer
  localparam int VALUE_W = 32;
  localparam int PCT_W   = 7;
  localparam int CELLS_W = 21;   // rows * columns
  localparam int NUM_W   = 28;   // (cells - nonzeros) * 100

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam logic [6:0]         PERCENT_SCALE = 7'd100;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  // register indexes on the configuration port
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // result kinds
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  // one classified element, handed from the front to the back
  typedef struct packed {
    logic                has_entry;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    column;
    logic                row_end;
    logic                last_row;
    logic [TALLY_W-1:0]  tally;
  } job_t;

  typedef struct packed {
    logic                kind;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    column;
    logic [TALLY_W-1:0]  pointer;
    logic                done;
    logic [PCT_W-1:0]    percent;
    logic                last;
  } result_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL,
    BK_DIV
  } bk_state_t;

  // zero reads as one, anything above the limit reads as the limit
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] raw,
                                                     input logic [COUNT_W-1:0] limit);
    logic [COUNT_W-1:0] res;
    if (raw == '0) begin
      res = COUNT_W'(1);
    end else if (raw > limit) begin
      res = limit;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/dtc_front.sv @@
// front end: takes elements, tracks row/column position and nonzero tally
// depends on dtc_pkg; feeds classified jobs into dtc_jobq
module dtc_front import dtc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  logic [COUNT_W-1:0] rows,
  input  logic [COUNT_W-1:0] cols,
  input  logic               accept,
  input  logic [VALUE_W-1:0] element_value,
  output logic               job_push,
  output job_t               job
);

  logic [POS_W-1:0]   col_pos;
  logic [POS_W-1:0]   row_pos;
  logic [TALLY_W-1:0] tally;
  logic [TALLY_W-1:0] tally_next;
  logic               nonzero;
  logic               row_end;
  logic               last_row;

  always_comb begin
    nonzero    = (element_value != '0);
    row_end    = (({1'b0, col_pos} + COUNT_W'(1)) >= cols);
    last_row   = (({1'b0, row_pos} + COUNT_W'(1)) >= rows);
    tally_next = (nonzero && (tally != TALLY_MAX)) ? tally + TALLY_W'(1) : tally;

    job.has_entry = nonzero;
    job.value     = element_value;
    job.column    = col_pos;
    job.row_end   = row_end;
    job.last_row  = last_row;
    job.tally     = tally_next;
    // a zero that does not close a row leaves nothing to do
    job_push      = accept && (nonzero || row_end);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_pos <= '0;
      row_pos <= '0;
      tally   <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos <= '0;
        if (last_row) begin
          row_pos <= '0;
          tally   <= '0;
        end else begin
          row_pos <= row_pos + POS_W'(1);
          tally   <= tally_next;
        end
      end else begin
        col_pos <= col_pos + POS_W'(1);
        tally   <= tally_next;
      end
    end
  end

endmodule

@@ hw/rtl/dtc_jobq.sv @@
// short job queue between front and back
// depends on dtc_pkg for job_t and the queue depth
module dtc_jobq import dtc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic valid,
  output logic full
);

  job_t               mem [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr;
  logic [JOBQ_AW-1:0] rd_ptr;
  logic [JOBQ_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    valid   = (count != '0);
    full    = (count == (JOBQ_AW+1)'(JOBQ_DEPTH));
    do_push = push && !full;
    do_pop  = pop && valid;
    head    = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + JOBQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + JOBQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (JOBQ_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (JOBQ_AW+1)'(1);
      end
    end
  end

endmodule

@@ hw/rtl/dtc_back.sv @@
// back end: turns jobs into results, computes the sparse percentage
// depends on dtc_pkg; drains dtc_jobq and holds the output register
module dtc_back import dtc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  job_t               job,
  input  logic               job_valid,
  input  logic [CELLS_W-1:0] cells,
  output logic               job_pop,
  input  logic               res_pop,
  output result_t            res,
  output logic               res_valid
);

  bk_state_t          state;
  bk_state_t          state_next;
  logic               phase;       // entry of the head job already sent
  logic               pct_ok;
  logic [NUM_W-1:0]   rem;
  logic [PCT_W-1:0]   quo;
  logic [2:0]         step;

  logic               slot_free;
  logic               at_row_end;
  logic               need_pct;
  logic               emit_entry;
  logic               emit_row_end;
  logic               start_mul;
  logic [CELLS_W-1:0] nz;
  logic [CELLS_W-1:0] diff;
  logic [NUM_W-1:0]   trial;
  logic               ge;
  result_t            res_new;

  always_comb begin
    slot_free  = !res_valid || res_pop;
    at_row_end = job_valid && (phase || !job.has_entry);
    need_pct   = job.last_row && (job.tally != '0);
    nz         = (job.tally > cells) ? cells : job.tally;
    diff       = cells - nz;
    trial      = NUM_W'(cells) << step;
    ge         = (rem >= trial);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_RUN: begin
        if (at_row_end && need_pct && !pct_ok) begin
          state_next = BK_MUL;
        end
      end
      BK_MUL: state_next = BK_DIV;
      BK_DIV: begin
        if (step == 3'd0) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit_entry   = 1'b0;
    emit_row_end = 1'b0;
    start_mul    = 1'b0;
    case (state)
      BK_RUN: begin
        emit_entry   = job_valid && !phase && job.has_entry && slot_free;
        emit_row_end = at_row_end && slot_free && (!need_pct || pct_ok);
        start_mul    = at_row_end && need_pct && !pct_ok;
      end
      default: begin
      end
    endcase
    job_pop = (emit_entry && !job.row_end) || emit_row_end;

    res_new = '0;
    if (emit_entry) begin
      res_new.kind   = KIND_ENTRY;
      res_new.value  = job.value;
      res_new.column = job.column;
      res_new.last   = !job.row_end;
    end else begin
      res_new.kind    = KIND_ROW_END;
      res_new.pointer = job.tally;
      res_new.done    = job.last_row;
      res_new.percent = need_pct ? quo : '0;
      res_new.last    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= 1'b0;
      pct_ok <= 1'b0;
    end else begin
      if (emit_entry && job.row_end) begin
        phase <= 1'b1;
      end else if (emit_row_end) begin
        phase <= 1'b0;
      end
      if (emit_row_end) begin
        pct_ok <= 1'b0;
      end else if (state == BK_DIV && step == 3'd0) begin
        pct_ok <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit a cycle (quotient never exceeds 100)
  always_ff @(posedge clk) begin
    if (start_mul) begin
      rem  <= NUM_W'(diff * PERCENT_SCALE);
      quo  <= '0;
      step <= 3'(PCT_W - 1);
    end else if (state == BK_DIV) begin
      if (ge) begin
        rem <= rem - trial;
      end
      quo[step] <= ge;
      step      <= step - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_entry || emit_row_end) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_entry || emit_row_end) begin
      res <= res_new;
    end
  end

endmodule

@@ hw/rtl/dense_to_csr_encoder.sv @@
// top level of the dense-to-csr encoder: config registers, front, queue, back
// depends on dtc_pkg, dtc_front, dtc_jobq and dtc_back
//
//   channel   handshake                       payload
//   --------  ------------------------------  ----------------------------------------
//   input     push / full                     element_value
//   result    pop / empty                     result_kind, entry_value, entry_column,
//                                             row_pointer, matrix_done, sparse_percent,
//                                             last_of_run
//   config    psel, penable, pwrite / pready  paddr, pwdata, prdata
//
// the front takes one element per cycle as long as the 4-deep job queue has room
// the back sends one result per cycle while pop is high and the divider is idle;
//   an element that is nonzero and closes a row gives two results
// the row end of a matrix with nonzeros waits in the back while the numerator
//   scaled by 100 is loaded, the multiply state passes and the seven quotient bits
//   of the percentage divider are worked out
// rst is synchronous; afterwards both counts read 1 and the block is ready at once
// full rises when the queue fills: a stalled result, the divider, two-result jobs

module dense_to_csr_encoder import dtc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // element request side
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  element_value,
  // result request side
  output logic                empty,
  input  logic                pop,
  output logic                result_kind,
  output logic signed [31:0]  entry_value,
  output logic [9:0]          entry_column,
  output logic [20:0]         row_pointer,
  output logic                matrix_done,
  output logic [6:0]          sparse_percent,
  output logic                last_of_run,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] rows;
  logic [COUNT_W-1:0] cols;
  logic [CELLS_W-1:0] cells;
  logic               cfg_wr;
  logic               accept;

  job_t               fe_job;
  logic               fe_push;
  job_t               jq_head;
  logic               jq_valid;
  logic               jq_full;
  logic               jq_pop;
  result_t            res;
  logic               res_valid;

  // apb register file: bit 2 of the address picks the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= COUNT_W'(1);
      column_count <= COUNT_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROW_COUNT:    row_count    <= pwdata[COUNT_W-1:0];
        REG_COLUMN_COUNT: column_count <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_COUNT:    prdata = {{(32-COUNT_W){1'b0}}, row_count};
      REG_COLUMN_COUNT: prdata = {{(32-COUNT_W){1'b0}}, column_count};
      default:          prdata = '0;
    endcase
  end

  // counts as used: zero means one, large values stop at the maximum
  assign rows = clamp_count(row_count, COUNT_W'(MAX_ROWS));
  assign cols = clamp_count(column_count, COUNT_W'(MAX_COLUMNS));

  // cell count only matters at a matrix end, long after a config write
  always_ff @(posedge clk) begin
    cells <= CELLS_W'(rows * cols);
  end

  assign full   = jq_full;
  assign accept = push && !full;

  dtc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_wr),
    .rows          (rows),
    .cols          (cols),
    .accept        (accept),
    .element_value (element_value),
    .job_push      (fe_push),
    .job           (fe_job)
  );

  dtc_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (fe_push),
    .push_job (fe_job),
    .pop      (jq_pop),
    .head     (jq_head),
    .valid    (jq_valid),
    .full     (jq_full)
  );

  dtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (jq_head),
    .job_valid (jq_valid),
    .cells     (cells),
    .job_pop   (jq_pop),
    .res_pop   (pop),
    .res       (res),
    .res_valid (res_valid)
  );

  assign empty          = !res_valid;
  assign result_kind    = res.kind;
  assign entry_value    = res.value;
  assign entry_column   = res.column;
  assign row_pointer    = res.pointer;
  assign matrix_done    = res.done;
  assign sparse_percent = res.percent;
  assign last_of_run    = res.last;

  // matrix end is only ever flagged on a row-end result
  a_done_on_row_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && matrix_done) |-> (result_kind == KIND_ROW_END))
    else $error("matrix_done on an entry result");

  // entry results never carry a zero value
  a_entry_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_ENTRY) |-> (entry_value != '0))
    else $error("entry result with zero value");

  // divider result stays within a percentage
  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (sparse_percent <= PCT_W'(100)))
    else $error("sparse percentage above 100");

  // an entry that closes a row is followed by its row end
  a_row_end_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result_kind == KIND_ENTRY && !last_of_run) |=>
      (empty || result_kind == KIND_ROW_END))
    else $error("row end missing after closing entry");

endmodule

@@ verif/dtc_csr_check.sv @@
`timescale 1ns / 1ps
// result checker for the dense-to-csr encoder: predicts the csr stream and compares it
// depends on dtc_pkg for the result layout, the register indexes and the count limits

module dtc_csr_check import dtc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic         full,
  input  logic [31:0]  element_value,
  input  logic         pop,
  input  logic         empty,
  input  logic         result_kind,
  input  logic [31:0]  entry_value,
  input  logic [9:0]   entry_column,
  input  logic [20:0]  row_pointer,
  input  logic         matrix_done,
  input  logic [6:0]   sparse_percent,
  input  logic         last_of_run,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           errors,
  output int           pending,
  output int           elements_seen,
  output int           results_seen,
  output int           matrices_seen
);

  logic [COUNT_W-1:0] rows_reg;
  logic [COUNT_W-1:0] cols_reg;
  logic [POS_W-1:0]   col_pos;
  logic [POS_W-1:0]   row_pos;
  logic [TALLY_W-1:0] nz_tally;
  result_t            csr_expected[$];

  initial begin
    errors = 0;
    pending = 0;
    elements_seen = 0;
    results_seen = 0;
    matrices_seen = 0;
  end

  // zero means one, anything past the cap means the cap
  function automatic int unsigned in_use(input logic [COUNT_W-1:0] raw,
                                         input int unsigned cap);
    int unsigned n;
    n = raw;
    if (n == 0) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  function automatic void restart_matrix();
    col_pos = '0;
    row_pos = '0;
    nz_tally = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 30) $display("%0t: csr mismatch: %s", $time, msg);
    errors++;
  endtask

  // one element in, zero to two csr requests expected
  function automatic void encode_element(input logic [31:0] v);
    int unsigned       rows;
    int unsigned       cols;
    bit                row_end;
    bit                last_row;
    longint unsigned   cells;
    longint unsigned   nz;
    result_t           r;
    rows = in_use(rows_reg, MAX_ROWS);
    cols = in_use(cols_reg, MAX_COLUMNS);
    row_end = (32'(col_pos) + 1) >= cols;
    last_row = (32'(row_pos) + 1) >= rows;
    if (v != '0) begin
      r = '0;
      r.kind = KIND_ENTRY;
      r.value = v;
      r.column = col_pos;
      r.last = !row_end;
      csr_expected.push_back(r);
      if (nz_tally != TALLY_MAX) nz_tally = nz_tally + 1'b1;
    end
    if (row_end) begin
      r = '0;
      r.kind = KIND_ROW_END;
      r.pointer = nz_tally;
      r.done = last_row;
      r.last = 1'b1;
      if (last_row && nz_tally != '0) begin
        cells = longint'(rows) * cols;
        nz = nz_tally;
        if (nz > cells) nz = cells;
        r.percent = PCT_W'(((cells - nz) * 100) / cells);
      end
      csr_expected.push_back(r);
      col_pos = '0;
      if (last_row) restart_matrix();
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  task automatic compare_result(input result_t got);
    result_t want;
    if (csr_expected.size() == 0) begin
      report_mismatch($sformatf("result request with nothing expected, kind %0d", got.kind));
    end else begin
      want = csr_expected.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report_mismatch($sformatf("entry_value %0h, want %0h", got.value, want.value));
      if (got.column !== want.column)
        report_mismatch($sformatf("entry_column %0d, want %0d", got.column, want.column));
      if (got.pointer !== want.pointer)
        report_mismatch($sformatf("row_pointer %0d, want %0d", got.pointer, want.pointer));
      if (got.done !== want.done)
        report_mismatch($sformatf("matrix_done %0d, want %0d", got.done, want.done));
      if (got.percent !== want.percent)
        report_mismatch($sformatf("sparse_percent %0d, want %0d", got.percent, want.percent));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_of_run %0d, want %0d", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    if (rst) begin
      rows_reg = COUNT_W'(1);
      cols_reg = COUNT_W'(1);
      restart_matrix();
      csr_expected.delete();
    end else begin
      if (pop && !empty) begin
        seen = {result_kind, entry_value, entry_column, row_pointer,
                matrix_done, sparse_percent, last_of_run};
        compare_result(seen);
        results_seen++;
        if (result_kind === KIND_ROW_END && matrix_done === 1'b1) matrices_seen++;
      end
      // any count write drops the matrix in progress
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_ROW_COUNT, 2'b00}) begin
          rows_reg = pwdata[COUNT_W-1:0];
          restart_matrix();
        end else if (paddr == {REG_COLUMN_COUNT, 2'b00}) begin
          cols_reg = pwdata[COUNT_W-1:0];
          restart_matrix();
        end
      end
      if (push && !full) begin
        encode_element(element_value);
        elements_seen++;
      end
    end
    pending <= csr_expected.size();
  end

endmodule

@@ verif/dense_to_csr_encoder_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the dense-to-csr encoder: clock, reset, element and count stimulus
// depends on dtc_pkg, dense_to_csr_encoder and dtc_csr_check

module dense_to_csr_encoder_tb;
  import dtc_pkg::*;

  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the job queue
  localparam int DRAIN_CYCLES = 20;      // margin for the job queue and the multiply and divide states to empty
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [2:0] ROW_COUNT_ADDR    = {REG_ROW_COUNT, 2'b00};
  localparam logic [2:0] COLUMN_COUNT_ADDR = {REG_COLUMN_COUNT, 2'b00};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] element_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               result_kind;
  logic signed [31:0] entry_value;
  logic [9:0]         entry_column;
  logic [20:0]        row_pointer;
  logic               matrix_done;
  logic [6:0]         sparse_percent;
  logic               last_of_run;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int  errors;
  int  pending;
  int  elements_seen;
  int  results_seen;
  int  matrices_seen;
  int  settings_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  hold_off_request = 1'b0;

  always #6 clk = ~clk;

  dense_to_csr_encoder dut (
    .clk, .rst,
    .push, .full, .element_value,
    .empty, .pop, .result_kind, .entry_value, .entry_column, .row_pointer,
    .matrix_done, .sparse_percent, .last_of_run,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dtc_csr_check csr_check (
    .clk, .rst,
    .push, .full, .element_value,
    .pop, .empty, .result_kind, .entry_value, .entry_column, .row_pointer,
    .matrix_done, .sparse_percent, .last_of_run,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .elements_seen, .results_seen, .matrices_seen
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: pop on a pattern that changes after a random stretch
  // mode 0 never stalls, the others stall more or less often
  initial begin : receiver
    int seg;
    int mode;
    forever begin
      seg = $urandom_range(4, 60);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        if (hold_off_request) begin
          // hold off long enough that the block backs up and raises full
          hold_off_request = 1'b0;
          pop <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: begin
            pop <= 1'b1;
          end
          1: begin
            pop <= 1'($urandom_range(0, 1));
          end
          2: begin
            pop <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            pop <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  // one register write: setup cycle, then access cycle
  // upper data bits are junk on purpose, only the low 11 bits count
  task automatic reg_write(input logic [2:0] addr, input logic [10:0] count);
    logic [31:0] data;
    data = $urandom();
    data[10:0] = count;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one element request; bursts of random length with random gaps between them
  // push stays high from one element to the next inside a burst
  task automatic send_element(input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (full);
  endtask

  // stop sending, let every expected result drain, then give zero elements still
  // in the pipe time to leave the block
  task automatic wait_idle();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(input logic [10:0] rows, input logic [10:0] cols);
    wait_idle();
    reg_write(ROW_COUNT_ADDR, rows);
    reg_write(COLUMN_COUNT_ADDR, cols);
    settings_count++;
  endtask

  // about half zeros, the rest a mix of full-range, small and boundary values
  function automatic logic [31:0] pick_element();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        v = '0;
      end
      6: begin
        v = $urandom_range(1, 9);
        if ($urandom_range(0, 1)) v = -v;
      end
      7: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  task automatic random_elements(input int n);
    repeat (n) send_element(pick_element());
  endtask

  initial begin : stimulus
    logic [10:0] rows;
    logic [10:0] cols;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // counts straight out of reset: 1x1, every element closes a matrix
    send_element(32'h0000_0000);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    send_element(32'hffff_ffff);
    send_element(32'h0000_0001);

    // row count of zero acts as one; single row of three
    // an all-zero matrix gives only its row end, with percent zero
    // one nonzero in three cells floors to 66 percent
    set_counts(11'd0, 11'd3);
    send_element(32'h0);
    send_element(32'h0);
    send_element(32'h0);
    send_element(32'h0);
    send_element(-32'sd5);
    send_element(32'h0);

    // 2x2, first row only, then a count write abandons the matrix
    // column count past the maximum is taken as the maximum
    set_counts(11'd2, 11'd2);
    send_element(32'd3);
    send_element(32'h0);
    wait_idle();
    reg_write(COLUMN_COUNT_ADDR, 11'd2047);
    send_element(32'd9);
    send_element(32'h0);
    send_element(32'h0);
    send_element(-32'sd9);

    // small random shapes, sometimes a zero count
    for (int phase = 0; phase < 10; phase++) begin
      rows = ($urandom_range(0, 7) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
      cols = ($urandom_range(0, 7) == 0) ? 11'd0 : 11'($urandom_range(1, 9));
      set_counts(rows, cols);
      if (phase == 2) hold_off_request = 1'b1;
      if (phase == 5) begin
        // sender pause mid-matrix until the block has drained completely
        random_elements(20);
        wait_idle();
      end
      random_elements($urandom_range(30, 60));
    end

    // row count past the maximum, one column: a tall matrix cut short
    set_counts(11'd2047, 11'd1);
    random_elements(90);
    // largest row count written exactly
    set_counts(11'd1024, 11'd2);
    random_elements(60);
    // one full row at the largest column count, every column index reached
    set_counts(11'd1, 11'd1024);
    random_elements(1024);

    wait_idle();
    $display("covered %0d elements and %0d results, %0d matrices closed",
             elements_seen, results_seen, matrices_seen);
    $display("over %0d count settings, %0d failed checks", settings_count, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
